### hw/rtl/bts_pkg.sv
// Shared types and constants of the buzzer tone sequencer.
// No dependencies; imported by every module of the block.
package bts_pkg;

  // opcodes of an input item
  localparam logic [2:0] OP_TICK        = 3'd0;
  localparam logic [2:0] OP_INIT        = 3'd1;
  localparam logic [2:0] OP_SUCCESS     = 3'd2;
  localparam logic [2:0] OP_FAILURE     = 3'd3;
  localparam logic [2:0] OP_CONFIRM     = 3'd4;
  localparam logic [2:0] OP_INTERACTION = 3'd5;
  localparam logic [2:0] OP_STEALTH     = 3'd6;

  // sound phases as reported on the result
  localparam logic [2:0] PH_IDLE        = 3'd0;
  localparam logic [2:0] PH_BOOT        = 3'd1;
  localparam logic [2:0] PH_NOTE1       = 3'd2;
  localparam logic [2:0] PH_GAP         = 3'd3;
  localparam logic [2:0] PH_NOTE2       = 3'd4;
  localparam logic [2:0] PH_FAILURE     = 3'd5;
  localparam logic [2:0] PH_CONFIRM     = 3'd6;
  localparam logic [2:0] PH_INTERACTION = 3'd7;

  // configuration register indexes
  localparam logic [2:0] CFG_FREQ_BOOT        = 3'd0;
  localparam logic [2:0] CFG_FREQ_SUCCESS_LOW = 3'd1;
  localparam logic [2:0] CFG_FREQ_SUCCESS_HI  = 3'd2;
  localparam logic [2:0] CFG_FREQ_FAILURE     = 3'd3;
  localparam logic [2:0] CFG_FREQ_CONFIRM     = 3'd4;
  localparam logic [2:0] CFG_FREQ_INTERACTION = 3'd5;

  // note and gap lengths in ms
  localparam logic [15:0] BOOT_MS        = 16'd200;
  localparam logic [15:0] SHORT_NOTE_MS  = 16'd100;
  localparam logic [15:0] GAP_MS         = 16'd50;
  localparam logic [15:0] FAILURE_MS     = 16'd300;
  localparam logic [15:0] CONFIRM_MS     = 16'd150;
  localparam logic [15:0] INTERACTION_MS = 16'd50;

  // timing and tone limits
  localparam logic [9:0]  MS_TICKS  = 10'd1000;
  localparam logic [15:0] FREQ_MIN  = 16'd50;
  localparam logic [15:0] FREQ_MAX  = 16'd20000;

  // half-period divider: one microsecond count per hertz
  localparam int unsigned    QUO_W     = 20;
  localparam logic [QUO_W-1:0] DIVIDEND = 20'd1000000;
  localparam logic [4:0]     DIV_STEPS = 5'd20;

  typedef struct packed {
    logic [2:0] opcode;
    logic       stealth_enable;
  } bts_in_t;

  typedef struct packed {
    logic       pin_level;
    logic       tone_on;
    logic [2:0] sound_phase;
    logic       ready_res;
  } bts_out_t;

  // controller to datapath
  typedef struct packed {
    logic exec;      // input transfer: apply the item
    logic div_step;  // one divider iteration
    logic div_last;  // final iteration, load the half period
    logic out_load;  // capture the result
  } bts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_need;  // the item being applied starts a tone
  } bts_status_t;

endpackage

### hw/rtl/bts_ctrl.sv
// Controller of the buzzer tone sequencer: item handshake, divider
// sequencing and result register valid. Depends on bts_pkg.
module bts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  bts_pkg::bts_status_t status_i,
  output bts_pkg::bts_cmd_t    cmd_o
);
  import bts_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    cmd_o          = '0;
    cmd_o.exec     = in_valid_i && (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.exec) begin
          cnt_d   = '0;
          state_d = status_i.div_need ? S_DIV : S_OUT;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_last = (cnt_q == DIV_STEPS - 5'd1);
        if (cmd_o.div_last) begin
          state_d = S_OUT;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_OUT: begin
        cmd_o.out_load = !out_valid_q || out_ready_i;
        if (cmd_o.out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result register valid
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### hw/rtl/bts_datapath.sv
// Datapath of the buzzer tone sequencer: note frequencies, sound state,
// half-period divider and result register. Depends on bts_pkg.
module bts_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bts_pkg::bts_cmd_t    cmd_i,
  input  bts_pkg::bts_in_t     in_data_i,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output bts_pkg::bts_status_t status_o,
  output bts_pkg::bts_out_t    out_data_o
);
  import bts_pkg::*;

  // note frequencies
  logic [15:0] f_boot_q, f_slow_q, f_shigh_q, f_fail_q, f_conf_q, f_inter_q;

  // sound state
  logic [2:0]  phase_q, phase_d;
  logic        init_q, init_d;
  logic        stealth_q, stealth_d;
  logic        tone_q, tone_d;
  logic        pin_q, pin_d;
  logic [13:0] half_q, half_d;
  logic [13:0] tc_q, tc_d;
  logic [9:0]  sub_q, sub_d;
  logic [15:0] el_q, el_d;

  // divider
  logic [15:0]      den_q, den_d;
  logic [15:0]      rem_q;
  logic [QUO_W-1:0] quo_q;
  logic [16:0]      rem_sh;
  logic             quo_bit;
  logic [15:0]      rem_nx;
  logic [QUO_W-1:0] quo_nx;

  logic [13:0] tc_inc;
  logic [9:0]  sub_inc;
  logic        start_en;
  logic [15:0] start_freq;
  logic        stop_en;
  logic        restart_en;

  bts_out_t out_q;

  assign tc_inc  = tc_q + 14'd1;
  assign sub_inc = sub_q + 10'd1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_boot_q  <= 16'd1000;
      f_slow_q  <= 16'd1500;
      f_shigh_q <= 16'd2000;
      f_fail_q  <= 16'd400;
      f_conf_q  <= 16'd1800;
      f_inter_q <= 16'd2500;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FREQ_BOOT:        f_boot_q  <= cfg_data_i;
        CFG_FREQ_SUCCESS_LOW: f_slow_q  <= cfg_data_i;
        CFG_FREQ_SUCCESS_HI:  f_shigh_q <= cfg_data_i;
        CFG_FREQ_FAILURE:     f_fail_q  <= cfg_data_i;
        CFG_FREQ_CONFIRM:     f_conf_q  <= cfg_data_i;
        CFG_FREQ_INTERACTION: f_inter_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item decode: which actions this item takes
  always_comb begin
    phase_d    = phase_q;
    init_d     = init_q;
    stealth_d  = stealth_q;
    pin_d      = pin_q;
    tc_d       = tc_q;
    sub_d      = sub_q;
    el_d       = el_q;
    start_en   = 1'b0;
    start_freq = f_boot_q;
    stop_en    = 1'b0;
    restart_en = 1'b0;
    if (cmd_i.exec) begin
      unique case (in_data_i.opcode) inside
        OP_TICK: begin
          if (init_q && !stealth_q) begin
            // square wave
            if (tone_q) begin
              if (tc_inc >= half_q) begin
                pin_d = ~pin_q;
                tc_d  = '0;
              end else begin
                tc_d = tc_inc;
              end
            end
            // millisecond count, saturating
            if (sub_inc >= MS_TICKS) begin
              sub_d = '0;
              if (el_q != 16'hFFFF) begin
                el_d = el_q + 16'd1;
              end
            end else begin
              sub_d = sub_inc;
            end
            // phase end on elapsed time
            case (phase_q)
              PH_BOOT: begin
                if (el_d >= BOOT_MS) begin
                  stop_en = 1'b1;
                  phase_d = PH_IDLE;
                end
              end
              PH_NOTE1: begin
                if (el_d >= SHORT_NOTE_MS) begin
                  stop_en    = 1'b1;
                  phase_d    = PH_GAP;
                  restart_en = 1'b1;
                end
              end
              PH_GAP: begin
                if (el_d >= GAP_MS) begin
                  start_en   = 1'b1;
                  start_freq = f_shigh_q;
                  phase_d    = PH_NOTE2;
                  restart_en = 1'b1;
                end
              end
              PH_NOTE2: begin
                if (el_d >= SHORT_NOTE_MS) begin
                  stop_en = 1'b1;
                  phase_d = PH_IDLE;
                end
              end
              PH_FAILURE: begin
                if (el_d >= FAILURE_MS) begin
                  stop_en = 1'b1;
                  phase_d = PH_IDLE;
                end
              end
              PH_CONFIRM: begin
                if (el_d >= CONFIRM_MS) begin
                  stop_en = 1'b1;
                  phase_d = PH_IDLE;
                end
              end
              PH_INTERACTION: begin
                if (el_d >= INTERACTION_MS) begin
                  stop_en = 1'b1;
                  phase_d = PH_IDLE;
                end
              end
              default: ;
            endcase
          end
        end
        OP_INIT: begin
          pin_d  = 1'b0;
          init_d = 1'b1;
          if (!stealth_q) begin
            phase_d    = PH_BOOT;
            restart_en = 1'b1;
            start_en   = 1'b1;
            start_freq = f_boot_q;
          end
        end
        OP_SUCCESS, OP_FAILURE, OP_CONFIRM, OP_INTERACTION: begin
          if (init_q && !stealth_q && (phase_q == PH_IDLE)) begin
            restart_en = 1'b1;
            start_en   = 1'b1;
            case (in_data_i.opcode)
              OP_SUCCESS: begin
                phase_d    = PH_NOTE1;
                start_freq = f_slow_q;
              end
              OP_FAILURE: begin
                phase_d    = PH_FAILURE;
                start_freq = f_fail_q;
              end
              OP_CONFIRM: begin
                phase_d    = PH_CONFIRM;
                start_freq = f_conf_q;
              end
              default: begin
                phase_d    = PH_INTERACTION;
                start_freq = f_inter_q;
              end
            endcase
          end
        end
        OP_STEALTH: begin
          stealth_d = in_data_i.stealth_enable;
          if (in_data_i.stealth_enable && (phase_q != PH_IDLE)) begin
            stop_en = init_q;
            phase_d = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // tone start and tone stop; an in-range start requests the divider
  always_comb begin
    tone_d            = tone_q;
    den_d             = den_q;
    status_o.div_need = 1'b0;
    if (stop_en) begin
      tone_d = 1'b0;
    end
    if (start_en && (start_freq >= FREQ_MIN) && (start_freq <= FREQ_MAX)) begin
      tone_d            = 1'b1;
      den_d             = start_freq;
      status_o.div_need = 1'b1;
    end
  end

  // restoring divider iteration
  always_comb begin
    rem_sh  = {rem_q, quo_q[QUO_W-1]};
    quo_bit = (rem_sh >= {1'b0, den_q});
    rem_nx  = quo_bit ? 16'(rem_sh - {1'b0, den_q}) : rem_sh[15:0];
    quo_nx  = {quo_q[QUO_W-2:0], quo_bit};
    half_d  = half_q;
    if (cmd_i.div_step && cmd_i.div_last) begin
      half_d = quo_nx[14:1];
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    if (status_o.div_need) begin
      rem_q <= '0;
      quo_q <= DIVIDEND;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_nx;
      quo_q <= quo_nx;
    end
  end

  // sound state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      init_q    <= 1'b0;
      stealth_q <= 1'b0;
      tone_q    <= 1'b0;
      pin_q     <= 1'b0;
      half_q    <= '0;
      tc_q      <= '0;
      sub_q     <= '0;
      el_q      <= '0;
    end else begin
      phase_q   <= phase_d;
      init_q    <= init_d;
      stealth_q <= stealth_d;
      tone_q    <= tone_d;
      pin_q     <= stop_en ? 1'b0 : pin_d;
      half_q    <= half_d;
      tc_q      <= status_o.div_need ? 14'd0 : tc_d;
      sub_q     <= restart_en ? 10'd0 : sub_d;
      el_q      <= restart_en ? 16'd0 : el_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.pin_level   <= pin_q;
      out_q.tone_on     <= tone_q;
      out_q.sound_phase <= phase_q;
      out_q.ready_res   <= init_q;
    end
  end

  assign out_data_o = out_q;

endmodule

### hw/rtl/buzzer_tone_sequencer_top.sv
// Top level of the buzzer tone sequencer: controller plus datapath.
// Depends on bts_pkg, bts_ctrl and bts_datapath.

// Each transfer on the input channel (a microsecond tick, init, a sound
// request or a stealth setting) yields exactly one result, the pin level,
// tone flag, sound phase and ready flag after that item. An item that does
// not start a tone goes from the transfer to the result load and then frees
// the input; one that starts a tone with a frequency in 50..20000 Hz first
// runs the 20-step restoring divider that derives the half period. Items
// are handled one at a time; the result register holds a result while the
// next item is taken. Configuration writes are always ready and are meant to
// come while the block is idle.
module buzzer_tone_sequencer_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bts_pkg::bts_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bts_pkg::bts_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);
  import bts_pkg::*;

  bts_cmd_t    cmd;
  bts_status_t status;

  assign cfg_ready_o = 1'b1;

  bts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bts_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

  // one item at a time: a transfer closes the input
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while an item is in progress");

  // no input while the divider runs
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> !in_ready_o)
    else $error("input ready during divider iterations");

  // before init there is no sound
  a_uninit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.ready_res) |->
      (out_data_o.sound_phase == PH_IDLE) && !out_data_o.tone_on)
    else $error("sound reported before init");

  // a result load only happens with no pending result or a taker
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("result overwritten before transfer");

endmodule

### sim/buzzer_tone_sequencer_top_test.sv
// Self-checking testbench of buzzer_tone_sequencer_top: directed rows, sound starts, random items.
// Results are checked against a behavioral predictor kept in this file.
// Depends on bts_pkg and the buzzer_tone_sequencer_top RTL.
`timescale 1ns / 100ps

module buzzer_tone_sequencer_top_test;
  import bts_pkg::*;

  localparam logic [2:0]  OP_SPARE        = 3'd7;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned SETTLE_CYCLES   = 30;
  localparam int unsigned WATCHDOG_CYCLES = 5000;
  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned PHASE_ITEMS     = 225;
  localparam int unsigned DIRECTED_COUNT  = 26;
  localparam int unsigned TONE_TICKS      = 40;

  // directed row: item, and the result where it is typed in
  typedef struct packed {
    logic [2:0] op;
    logic       en;
    logic       fixed;
    logic       pin;
    logic       tone;
    logic [2:0] ph;
    logic       rdy;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{OP_TICK,        1'b0, 1'b1, 1'b0, 1'b0, PH_IDLE,        1'b0},
    '{OP_SUCCESS,     1'b0, 1'b1, 1'b0, 1'b0, PH_IDLE,        1'b0},
    '{OP_STEALTH,     1'b0, 1'b1, 1'b0, 1'b0, PH_IDLE,        1'b0},
    '{OP_SPARE,       1'b1, 1'b1, 1'b0, 1'b0, PH_IDLE,        1'b0},
    '{OP_INIT,        1'b0, 1'b1, 1'b0, 1'b1, PH_BOOT,        1'b1},
    '{OP_TICK,        1'b0, 1'b0, 1'b0, 1'b0, PH_IDLE,        1'b0},
    '{OP_FAILURE,     1'b1, 1'b1, 1'b0, 1'b1, PH_BOOT,        1'b1},
    '{OP_STEALTH,     1'b1, 1'b1, 1'b0, 1'b0, PH_IDLE,        1'b1},
    '{OP_CONFIRM,     1'b0, 1'b1, 1'b0, 1'b0, PH_IDLE,        1'b1},
    '{OP_TICK,        1'b1, 1'b1, 1'b0, 1'b0, PH_IDLE,        1'b1},
    '{OP_INIT,        1'b1, 1'b1, 1'b0, 1'b0, PH_IDLE,        1'b1},
    '{OP_STEALTH,     1'b0, 1'b1, 1'b0, 1'b0, PH_IDLE,        1'b1},
    '{OP_SPARE,       1'b0, 1'b1, 1'b0, 1'b0, PH_IDLE,        1'b1},
    '{OP_INTERACTION, 1'b0, 1'b1, 1'b0, 1'b1, PH_INTERACTION, 1'b1},
    '{OP_SUCCESS,     1'b1, 1'b1, 1'b0, 1'b1, PH_INTERACTION, 1'b1},
    '{OP_INIT,        1'b0, 1'b1, 1'b0, 1'b1, PH_BOOT,        1'b1},
    '{OP_STEALTH,     1'b1, 1'b0, 1'b0, 1'b0, PH_IDLE,        1'b0},
    '{OP_STEALTH,     1'b0, 1'b0, 1'b0, 1'b0, PH_IDLE,        1'b0},
    '{OP_SUCCESS,     1'b0, 1'b1, 1'b0, 1'b1, PH_NOTE1,       1'b1},
    '{OP_TICK,        1'b0, 1'b0, 1'b0, 1'b0, PH_IDLE,        1'b0},
    '{OP_STEALTH,     1'b1, 1'b0, 1'b0, 1'b0, PH_IDLE,        1'b0},
    '{OP_STEALTH,     1'b0, 1'b0, 1'b0, 1'b0, PH_IDLE,        1'b0},
    '{OP_FAILURE,     1'b0, 1'b1, 1'b0, 1'b1, PH_FAILURE,     1'b1},
    '{OP_STEALTH,     1'b1, 1'b0, 1'b0, 1'b0, PH_IDLE,        1'b0},
    '{OP_STEALTH,     1'b0, 1'b0, 1'b0, 1'b0, PH_IDLE,        1'b0},
    '{OP_CONFIRM,     1'b0, 1'b1, 1'b0, 1'b1, PH_CONFIRM,     1'b1}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  bts_in_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  bts_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i  = '0;

  // stimulus control shared with the receiver
  bit no_idle  = 1'b0;
  bit hold_req = 1'b0;

  int unsigned mismatches = 0;

  // predicted buzzer state and frequency registers
  logic [15:0] note_freq [6];
  logic [2:0]  ph_now;
  logic        armed;
  logic        stealth_on;
  logic        tone_live;
  logic        pin_q;
  logic [13:0] half_us;
  logic [13:0] toggle_cnt;
  logic [9:0]  us_cnt;
  logic [15:0] ms_cnt;

  bts_out_t pending_levels_q [$];

  buzzer_tone_sequencer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // tone start: out-of-range frequency leaves the tone as it was
  function automatic void start_tone(input logic [15:0] freq);
    if (!armed || stealth_on) return;
    if (freq < FREQ_MIN || freq > FREQ_MAX) return;
    tone_live  = 1'b1;
    toggle_cnt = '0;
    half_us    = 14'((1000000 / int'(freq)) / 2);
  endfunction

  function automatic void stop_tone();
    if (!armed) return;
    tone_live = 1'b0;
    pin_q     = 1'b0;
  endfunction

  function automatic void play_sound(input logic [2:0] ph, input logic [15:0] freq);
    if (!armed || stealth_on || ph_now != PH_IDLE) return;
    ph_now = ph;
    ms_cnt = '0;
    us_cnt = '0;
    start_tone(freq);
  endfunction

  // end a sound once its length in ms is reached
  function automatic void end_after(input logic [15:0] len_ms);
    if (ms_cnt >= len_ms) begin
      stop_tone();
      ph_now = PH_IDLE;
    end
  endfunction

  // one microsecond: pin toggle, ms count, phase timing
  function automatic void tick_us();
    if (!armed || stealth_on) return;
    if (tone_live) begin
      toggle_cnt = toggle_cnt + 14'd1;
      if (toggle_cnt >= half_us) begin
        pin_q      = ~pin_q;
        toggle_cnt = '0;
      end
    end
    us_cnt = us_cnt + 10'd1;
    if (us_cnt >= MS_TICKS) begin
      us_cnt = '0;
      if (ms_cnt != 16'hFFFF) ms_cnt = ms_cnt + 16'd1;
    end
    case (ph_now)
      PH_BOOT:        end_after(BOOT_MS);
      PH_NOTE1: begin
        if (ms_cnt >= SHORT_NOTE_MS) begin
          stop_tone();
          ph_now = PH_GAP;
          ms_cnt = '0;
          us_cnt = '0;
        end
      end
      PH_GAP: begin
        if (ms_cnt >= GAP_MS) begin
          start_tone(note_freq[CFG_FREQ_SUCCESS_HI]);
          ph_now = PH_NOTE2;
          ms_cnt = '0;
          us_cnt = '0;
        end
      end
      PH_NOTE2:       end_after(SHORT_NOTE_MS);
      PH_FAILURE:     end_after(FAILURE_MS);
      PH_CONFIRM:     end_after(CONFIRM_MS);
      PH_INTERACTION: end_after(INTERACTION_MS);
      default: ;
    endcase
  endfunction

  // apply one item to the predicted state, return the levels after it
  function automatic bts_out_t predict_levels(input bts_in_t item);
    bts_out_t res;
    case (item.opcode)
      OP_TICK: tick_us();
      OP_INIT: begin
        pin_q = 1'b0;
        armed = 1'b1;
        if (!stealth_on) begin
          ph_now = PH_BOOT;
          ms_cnt = '0;
          us_cnt = '0;
          start_tone(note_freq[CFG_FREQ_BOOT]);
        end
      end
      OP_SUCCESS:     play_sound(PH_NOTE1, note_freq[CFG_FREQ_SUCCESS_LOW]);
      OP_FAILURE:     play_sound(PH_FAILURE, note_freq[CFG_FREQ_FAILURE]);
      OP_CONFIRM:     play_sound(PH_CONFIRM, note_freq[CFG_FREQ_CONFIRM]);
      OP_INTERACTION: play_sound(PH_INTERACTION, note_freq[CFG_FREQ_INTERACTION]);
      OP_STEALTH: begin
        stealth_on = item.stealth_enable;
        if (item.stealth_enable && ph_now != PH_IDLE) begin
          stop_tone();
          ph_now = PH_IDLE;
        end
      end
      default: ;
    endcase
    res.pin_level   = pin_q;
    res.tone_on     = tone_live;
    res.sound_phase = ph_now;
    res.ready_res   = armed;
    return res;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_freq();
    case ($urandom_range(0, 11))
      0:       return 16'd0;
      1:       return 16'(FREQ_MIN - 16'd1);
      2:       return FREQ_MIN;
      3:       return FREQ_MAX;
      4:       return 16'(FREQ_MAX + 16'd1);
      5:       return 16'hFFFF;
      6, 7, 8: return 16'($urandom_range(2000, 20000));
      9, 10:   return 16'($urandom_range(50, 20000));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic bts_in_t random_item();
    bts_in_t item;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 78)      item.opcode = OP_TICK;
    else if (r < 81) item.opcode = OP_INIT;
    else if (r < 84) item.opcode = OP_SUCCESS;
    else if (r < 86) item.opcode = OP_FAILURE;
    else if (r < 88) item.opcode = OP_CONFIRM;
    else if (r < 91) item.opcode = OP_INTERACTION;
    else if (r < 98) item.opcode = OP_STEALTH;
    else             item.opcode = OP_SPARE;
    item.stealth_enable = ($urandom_range(0, 9) < 3);
    return item;
  endfunction

  // one input transfer; the expectation is the typed one or the predicted one
  task automatic send_item(input bts_in_t item, input bit fixed, input bts_out_t fixed_res);
    bts_out_t res;
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    res = predict_levels(item);
    pending_levels_q.push_back(fixed ? fixed_res : res);
    gap = no_idle ? 0 : idle_len();
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_op(input logic [2:0] op, input logic en);
    bts_in_t item;
    item.opcode         = op;
    item.stealth_enable = en;
    send_item(item, 1'b0, '0);
  endtask

  // drop valid, wait for every result, then wait with the block idle
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_levels_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    note_freq[idx] = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_freqs(input logic [15:0] boot, input logic [15:0] lo,
                            input logic [15:0] hi, input logic [15:0] fail,
                            input logic [15:0] conf, input logic [15:0] inter);
    write_reg(CFG_FREQ_BOOT, boot);
    write_reg(CFG_FREQ_SUCCESS_LOW, lo);
    write_reg(CFG_FREQ_SUCCESS_HI, hi);
    write_reg(CFG_FREQ_FAILURE, fail);
    write_reg(CFG_FREQ_CONFIRM, conf);
    write_reg(CFG_FREQ_INTERACTION, inter);
  endtask

  // result receiver: random stalls, one long hold on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (no_idle) begin
        out_ready_i <= 1'b1;
      end else begin
        stall_left = idle_len();
        out_ready_i <= (stall_left == 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    bts_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_levels_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: pin %0b tone %0b phase %0d ready %0b",
                   out_data_o.pin_level, out_data_o.tone_on,
                   out_data_o.sound_phase, out_data_o.ready_res);
      end else begin
        want = pending_levels_q.pop_front();
        if (out_data_o.pin_level !== want.pin_level || out_data_o.tone_on !== want.tone_on ||
            out_data_o.sound_phase !== want.sound_phase ||
            out_data_o.ready_res !== want.ready_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected pin %0b tone %0b phase %0d ready %0b, got %0b %0b %0d %0b",
                     want.pin_level, want.tone_on, want.sound_phase, want.ready_res,
                     out_data_o.pin_level, out_data_o.tone_on,
                     out_data_o.sound_phase, out_data_o.ready_res);
        end
      end
    end
  end

  // watchdog: too many cycles without any transfer
  initial begin
    int unsigned still_edges;
    still_edges = 0;
    @(posedge rst_ni);
    while (still_edges < WATCHDOG_CYCLES) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        still_edges = 0;
      else
        still_edges++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // main sequence
  initial begin
    bts_in_t  item;
    bts_out_t fixed_res;
    int unsigned i;
    int unsigned p;

    note_freq[CFG_FREQ_BOOT]        = 16'd1000;
    note_freq[CFG_FREQ_SUCCESS_LOW] = 16'd1500;
    note_freq[CFG_FREQ_SUCCESS_HI]  = 16'd2000;
    note_freq[CFG_FREQ_FAILURE]     = 16'd400;
    note_freq[CFG_FREQ_CONFIRM]     = 16'd1800;
    note_freq[CFG_FREQ_INTERACTION] = 16'd2500;
    ph_now     = PH_IDLE;
    armed      = 1'b0;
    stealth_on = 1'b0;
    tone_live  = 1'b0;
    pin_q      = 1'b0;
    half_us    = '0;
    toggle_cnt = '0;
    us_cnt     = '0;
    ms_cnt     = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows with reset frequencies
    for (i = 0; i < DIRECTED_COUNT; i++) begin
      item.opcode           = DIRECTED_ROWS[i].op;
      item.stealth_enable   = DIRECTED_ROWS[i].en;
      fixed_res.pin_level   = DIRECTED_ROWS[i].pin;
      fixed_res.tone_on     = DIRECTED_ROWS[i].tone;
      fixed_res.sound_phase = DIRECTED_ROWS[i].ph;
      fixed_res.ready_res   = DIRECTED_ROWS[i].rdy;
      send_item(item, DIRECTED_ROWS[i].fixed, fixed_res);
    end

    // sound starts without idling: interaction, then success, each followed by a run of ticks
    settle();
    load_freqs(16'd1000, FREQ_MAX, FREQ_MIN, 16'd400, 16'd1800, 16'd4000);
    no_idle = 1'b1;
    send_op(OP_STEALTH, 1'b1);
    send_op(OP_INIT, 1'b0);
    send_op(OP_STEALTH, 1'b0);
    send_op(OP_INTERACTION, 1'b0);
    repeat (TONE_TICKS) send_op(OP_TICK, 1'b0);
    send_op(OP_STEALTH, 1'b1);
    send_op(OP_STEALTH, 1'b0);
    send_op(OP_SUCCESS, 1'b0);
    repeat (TONE_TICKS) send_op(OP_TICK, 1'b0);
    no_idle = 1'b0;

    // random items under several frequency settings
    for (p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      if (p == 0)
        load_freqs(16'd0, 16'(FREQ_MIN - 16'd1), FREQ_MIN, FREQ_MAX,
                   16'(FREQ_MAX + 16'd1), 16'hFFFF);
      else
        load_freqs(pick_freq(), pick_freq(), pick_freq(), pick_freq(), pick_freq(),
                   pick_freq());
      no_idle = (p == RANDOM_PHASES - 1);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // long receiver hold while items keep coming
        if (i == PHASE_ITEMS / 2 && p == 1) hold_req = 1'b1;
        // sender pause until every result is back
        if (i == (PHASE_ITEMS * 3) / 4) settle();
        send_item(random_item(), 1'b0, '0);
      end
      no_idle = 1'b0;
    end

    settle();
    if (mismatches == 0 && pending_levels_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/bts_pkg.sv
hw/rtl/bts_ctrl.sv
hw/rtl/bts_datapath.sv
hw/rtl/buzzer_tone_sequencer_top.sv
sim/buzzer_tone_sequencer_top_test.sv
